[hw/rtl/tga_rle_pixel_decoder_assert.svh]
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder assertion macros
// Shared concurrent assertion forms; they expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tga assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TGA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tga assertion failed");

`endif

[hw/rtl/tga_pkg.sv]
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder package
// Shared types and constants for the parser, the queue and the counter stage.
// ----------------------------------------------------------------------------
package tga_pkg;

	localparam int BPP_W   = 3;
	localparam int TOTAL_W = 25;
	localparam int CFG_W   = 25;

	// Register indexes on the configuration port.
	localparam logic REG_BPP   = 1'b0;
	localparam logic REG_TOTAL = 1'b1;

	localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;
	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 25'd1;
	localparam logic [BPP_W-1:0]   BPP_MIN     = 3'd1;
	localparam logic [BPP_W-1:0]   BPP_MAX     = 3'd4;

	localparam logic [7:0] RAW_LIMIT   = 8'd128;
	localparam logic [7:0] REPEAT_BIAS = 8'd127;

	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// One completed pixel on its way from the parser to the counter stage.
	typedef struct packed {
		logic [31:0] pixel;
		logic [7:0]  count;
		logic        new_frame;
	} tga_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tga_qstat_t;

endpackage

[hw/rtl/tga_stream_ifs.sv]
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder stream interfaces
// Valid/ready channels for the coded byte stream and the decoded pixels.
// ----------------------------------------------------------------------------
interface tga_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface tga_pixel_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_value;
	logic [7:0]  repeat_count;
	logic        image_done;
	logic        overflow_error;

	modport source (output valid, output pixel_value, output repeat_count,
		output image_done, output overflow_error, input ready);
	modport sink (input valid, input pixel_value, input repeat_count,
		input image_done, input overflow_error, output ready);
endinterface

[hw/rtl/tga_rle_pixel_decoder.sv]
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Decodes the run-length coded pixel stream of a TGA image into pixel runs.
// ----------------------------------------------------------------------------
// byte_in carries one coded byte per request; frame_start on a byte clears the
// counters and the sticky stop, and that byte is taken as a packet header.
// pixel_out gives one request per completed pixel: its value, repeat count and
// the completion and overflow flags. After either flag, further bytes are
// dropped until the next frame start.
// One byte is taken every cycle while the two-entry queue has room. The parser
// writes a completed pixel into the queue at the edge that takes its last
// byte; the counter stage pops it into the output register when that register
// is empty or being read, and pixel_out.valid rises unless output has stopped.
// When pixel_out stalls the output register holds, the queue fills, and
// byte_in.ready falls once both queue entries are taken.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while idle, which the block does not enforce. Reset sets four
// bytes per pixel, a total of one pixel and an empty pipeline; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
	parameter int PIXEL_COUNT_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	tga_byte_if.sink                  byte_in,
	tga_pixel_if.source               pixel_out,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [tga_pkg::CFG_W-1:0] cfg_data
);

	logic [tga_pkg::BPP_W-1:0]   bpp_q;
	logic [tga_pkg::TOTAL_W-1:0] total_q;

	logic                push;
	logic                pop;
	tga_pkg::tga_item_t  push_item;
	tga_pkg::tga_item_t  pop_item;
	tga_pkg::tga_qstat_t qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q   <= tga_pkg::BPP_RESET;
			total_q <= tga_pkg::TOTAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tga_pkg::REG_BPP:   bpp_q   <= cfg_data[tga_pkg::BPP_W-1:0];
				tga_pkg::REG_TOTAL: total_q <= cfg_data[tga_pkg::TOTAL_W-1:0];
				default: ;
			endcase
		end
	end

	tga_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_in         (byte_in),
		.bytes_per_pixel (bpp_q),
		.qstat           (qstat),
		.push            (push),
		.push_item       (push_item)
	);

	tga_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.qstat     (qstat)
	);

	tga_back #(
		.PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_total (total_q),
		.qstat       (qstat),
		.pop_item    (pop_item),
		.pop         (pop),
		.pixel_out   (pixel_out)
	);

endmodule

[hw/rtl/tga_queue.sv]
// ----------------------------------------------------------------------------
// TGA pixel queue
// Short first-in first-out store between the parser and the counter stage.
// ----------------------------------------------------------------------------
module tga_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tga_pkg::tga_item_t  push_item,
	input  logic                pop,
	output tga_pkg::tga_item_t  pop_item,
	output tga_pkg::tga_qstat_t qstat
);

	tga_pkg::tga_item_t mem_q [tga_pkg::QUEUE_DEPTH];
	logic [tga_pkg::PTR_W-1:0] wr_ptr_q;
	logic [tga_pkg::PTR_W-1:0] rd_ptr_q;
	logic [tga_pkg::CNT_W-1:0] count_q;

	function automatic logic [tga_pkg::PTR_W-1:0] next_ptr(input logic [tga_pkg::PTR_W-1:0] p);
		if (p == tga_pkg::PTR_W'(tga_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + tga_pkg::PTR_W'(1);
	endfunction

	assign qstat.full  = (count_q == tga_pkg::CNT_W'(tga_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + tga_pkg::CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - tga_pkg::CNT_W'(1);
			end
		end
	end

endmodule

[hw/rtl/tga_front.sv]
// ----------------------------------------------------------------------------
// TGA packet parser
// Takes coded bytes, tracks packet headers and assembles pixels for the queue.
// ----------------------------------------------------------------------------
module tga_front (
	input  logic                      clk,
	input  logic                      arst_n,
	tga_byte_if.sink                  byte_in,
	input  logic [tga_pkg::BPP_W-1:0] bytes_per_pixel,
	input  tga_pkg::tga_qstat_t       qstat,
	output logic                      push,
	output tga_pkg::tga_item_t        push_item
);

	logic        expect_q;
	logic        repeat_q;
	logic [7:0]  left_q;
	logic [7:0]  run_q;
	logic [1:0]  bpos_q;
	logic [31:0] acc_q;
	logic        pend_q;

	logic                      accept;
	logic                      expect_e;
	logic                      pend_e;
	logic [tga_pkg::BPP_W-1:0] bpp_c;
	logic                      last_byte;
	logic [31:0]               acc_n;
	logic [7:0]                left_dec;

	always_comb begin
		accept   = byte_in.valid && byte_in.ready;
		// A frame start turns the byte into a header and tags the next pixel.
		expect_e = byte_in.frame_start || expect_q;
		pend_e   = byte_in.frame_start || pend_q;
		if (bytes_per_pixel == '0) begin
			bpp_c = tga_pkg::BPP_MIN;
		end else if (bytes_per_pixel > tga_pkg::BPP_MAX) begin
			bpp_c = tga_pkg::BPP_MAX;
		end else begin
			bpp_c = bytes_per_pixel;
		end
		last_byte = ({1'b0, bpos_q} + 3'd1) >= bpp_c;
		if (bpos_q == 2'd0) begin
			acc_n = {24'd0, byte_in.data_byte};
		end else begin
			acc_n = acc_q | ({24'd0, byte_in.data_byte} << {bpos_q, 3'b000});
		end
		left_dec = (left_q == 8'd0) ? 8'd0 : left_q - 8'd1;
		push     = accept && !expect_e && last_byte;
		push_item.pixel     = acc_n;
		push_item.count     = repeat_q ? run_q : 8'd1;
		push_item.new_frame = pend_e;
	end

	assign byte_in.ready = !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= 1'b1;
			repeat_q <= 1'b0;
			left_q   <= '0;
			run_q    <= '0;
			bpos_q   <= '0;
			acc_q    <= '0;
			pend_q   <= 1'b0;
		end else if (accept) begin
			pend_q <= push ? 1'b0 : pend_e;
			if (expect_e) begin
				expect_q <= 1'b0;
				bpos_q   <= '0;
				acc_q    <= '0;
				if (byte_in.data_byte < tga_pkg::RAW_LIMIT) begin
					repeat_q <= 1'b0;
					left_q   <= byte_in.data_byte + 8'd1;
					run_q    <= 8'd1;
				end else begin
					repeat_q <= 1'b1;
					left_q   <= 8'd1;
					run_q    <= byte_in.data_byte - tga_pkg::REPEAT_BIAS;
				end
			end else if (!last_byte) begin
				bpos_q <= bpos_q + 2'd1;
				acc_q  <= acc_n;
			end else begin
				bpos_q <= '0;
				left_q <= left_dec;
				if (left_dec == 8'd0) begin
					expect_q <= 1'b1;
				end
			end
		end
	end

endmodule

[hw/rtl/tga_back.sv]
// ----------------------------------------------------------------------------
// TGA pixel counter stage
// Counts pixels against the image total, flags completion and overflow.
// ----------------------------------------------------------------------------
`include "tga_rle_pixel_decoder_assert.svh"

module tga_back #(
	parameter int PIXEL_COUNT_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tga_pkg::TOTAL_W-1:0] pixel_total,
	input  tga_pkg::tga_qstat_t         qstat,
	input  tga_pkg::tga_item_t          pop_item,
	output logic                        pop,
	tga_pixel_if.source                 pixel_out
);

	localparam int EW = PIXEL_COUNT_BITS + 1;
	localparam int TW = (EW > tga_pkg::TOTAL_W) ? EW : tga_pkg::TOTAL_W;
	localparam int SW = TW + 1;
	localparam logic [SW-1:0] CAP = {{(SW-1){1'b0}}, 1'b1} << PIXEL_COUNT_BITS;

	logic [EW-1:0] emitted_q;
	logic          stopped_q;
	logic          out_valid_q;
	logic [31:0]   pixel_q;
	logic [7:0]    count_q;
	logic          done_q;
	logic          ovf_q;

	logic          stopped_e;
	logic [EW-1:0] emitted_e;
	logic [SW-1:0] sum;
	logic [SW-1:0] total_ext;
	logic [SW-1:0] total_c;
	logic          ovf;
	logic          done;
	logic          emit;

	always_comb begin
		pop       = !qstat.empty && (!out_valid_q || pixel_out.ready);
		// The first pixel of a new frame sees cleared counters.
		stopped_e = pop_item.new_frame ? 1'b0 : stopped_q;
		emitted_e = pop_item.new_frame ? '0 : emitted_q;
		sum       = SW'(emitted_e) + SW'(pop_item.count);
		total_ext = SW'(pixel_total);
		total_c   = (total_ext > CAP) ? CAP : total_ext;
		ovf       = sum > total_c;
		done      = sum == total_c;
		emit      = pop && !stopped_e;
	end

	assign pixel_out.valid          = out_valid_q;
	assign pixel_out.pixel_value    = pixel_q;
	assign pixel_out.repeat_count   = count_q;
	assign pixel_out.image_done     = done_q;
	assign pixel_out.overflow_error = ovf_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_q <= pop_item.pixel;
			count_q <= pop_item.count;
			ovf_q   <= ovf;
			done_q  <= done && !ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emitted_q   <= '0;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				stopped_q <= stopped_e || ovf || done;
				if (!stopped_e && !ovf) begin
					emitted_q <= EW'(sum);
				end else begin
					emitted_q <= emitted_e;
				end
				out_valid_q <= emit;
			end else if (pixel_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`TGA_ASSERT_IMP(a_done_ovf_excl, pixel_out.valid, !(pixel_out.image_done && pixel_out.overflow_error))
	`TGA_ASSERT_IMP(a_count_nonzero, pixel_out.valid, pixel_out.repeat_count != 8'd0)
	`TGA_ASSERT_NEXT(a_stop_after_end, emit && (ovf || done), stopped_q)

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder testbench
// Feeds coded byte streams through the byte channel with random gaps and
// back-pressure. Each accepted byte is decoded by a local model of the packet
// parser and pixel counter. Every pixel run that comes out is checked against
// the oldest predicted run. The run covers all pixel sizes and small and
// extreme totals.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COUNT_BITS   = 24;
	localparam int DRAIN_CYCLES = 10;
	localparam int STALL_LIMIT  = 2000;

	typedef struct {
		logic [7:0] data;
		logic       frame_start;
	} coded_byte_t;

	typedef struct {
		logic [31:0] pixel;
		logic [7:0]  count;
		logic        done;
		logic        overflow;
	} pixel_run_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [tga_pkg::CFG_W-1:0] cfg_data;

	tga_byte_if  byte_if ();
	tga_pixel_if pix_if ();

	tga_rle_pixel_decoder #(
		.PIXEL_COUNT_BITS(COUNT_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_if),
		.pixel_out (pix_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	coded_byte_t byte_stream[$];
	pixel_run_t  expected_runs[$];
	int          bytes_queued;
	int          bytes_taken;
	int          mismatches;
	int          quiet_cycles;
	int          send_idle_pct;
	int          recv_stall_pct;

	// Local copy of the configuration and of the decoding state.
	logic [tga_pkg::BPP_W-1:0]   cfg_bpp;
	logic [tga_pkg::TOTAL_W-1:0] cfg_total;
	bit                          dec_want_header;
	bit                          dec_repeat;
	int                          dec_left;
	int                          dec_run;
	int                          dec_pos;
	logic [31:0]                 dec_acc;
	longint                      dec_emitted;
	bit                          dec_stopped;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic void clear_decoder();
		dec_want_header = 1'b1;
		dec_repeat      = 1'b0;
		dec_left        = 0;
		dec_run         = 0;
		dec_pos         = 0;
		dec_acc         = '0;
		dec_emitted     = 0;
		dec_stopped     = 1'b0;
	endfunction

	function automatic int pixel_bytes(input logic [tga_pkg::BPP_W-1:0] bpp);
		if (bpp == 0)
			return 1;
		if (bpp > 4)
			return 4;
		return int'(bpp);
	endfunction

	// Works out the pixel run, if any, that one accepted byte completes.
	function automatic void decode_byte(input logic [7:0] b, input logic frame_start);
		int         size;
		longint     cap;
		longint     sum;
		pixel_run_t run;
		if (frame_start)
			clear_decoder();
		if (dec_stopped)
			return;
		if (dec_want_header) begin
			dec_want_header = 1'b0;
			dec_pos = 0;
			dec_acc = '0;
			if (b < tga_pkg::RAW_LIMIT) begin
				dec_repeat = 1'b0;
				dec_left   = int'(b) + 1;
				dec_run    = 1;
			end else begin
				dec_repeat = 1'b1;
				dec_left   = 1;
				dec_run    = int'(b) - int'(tga_pkg::REPEAT_BIAS);
			end
			return;
		end
		size = pixel_bytes(cfg_bpp);
		if (dec_pos == 0)
			dec_acc = 32'(b);
		else
			dec_acc = dec_acc | (32'(b) << (8 * dec_pos));
		if (dec_pos + 1 < size) begin
			dec_pos++;
			return;
		end
		dec_pos = 0;
		run.pixel    = dec_acc;
		run.count    = dec_repeat ? 8'(dec_run) : 8'd1;
		run.done     = 1'b0;
		run.overflow = 1'b0;
		cap = longint'(cfg_total);
		if (cap > (longint'(1) << COUNT_BITS))
			cap = longint'(1) << COUNT_BITS;
		sum = dec_emitted + (dec_repeat ? dec_run : 1);
		if (sum > cap) begin
			run.overflow = 1'b1;
			dec_stopped  = 1'b1;
		end else begin
			dec_emitted = sum;
			if (sum == cap) begin
				run.done    = 1'b1;
				dec_stopped = 1'b1;
			end else begin
				if (dec_left > 0)
					dec_left--;
				if (dec_left == 0)
					dec_want_header = 1'b1;
			end
		end
		expected_runs.push_back(run);
	endfunction

	task automatic compare_field(input string name, input logic [31:0] exp_val,
		input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			mismatches++;
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
		end
	endtask

	// Byte channel: one request held until taken, then the next one or a gap.
	always @(posedge clk) begin
		coded_byte_t req;
		if (arst_n) begin
			if (byte_if.valid && byte_if.ready) begin
				decode_byte(byte_if.data_byte, byte_if.frame_start);
				bytes_taken++;
			end
			if (!byte_if.valid || byte_if.ready) begin
				if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req = byte_stream.pop_front();
					byte_if.valid       <= 1'b1;
					byte_if.data_byte   <= req.data;
					byte_if.frame_start <= req.frame_start;
				end else begin
					byte_if.valid <= 1'b0;
				end
			end
		end
	end

	// Pixel channel: compares each accepted request with the oldest prediction.
	always @(posedge clk) begin
		pixel_run_t want;
		if (arst_n) begin
			if (pix_if.valid && pix_if.ready) begin
				if (expected_runs.size() == 0) begin
					mismatches++;
					$error("unexpected pixel run: pixel_value 0x%0h repeat_count %0d",
						pix_if.pixel_value, pix_if.repeat_count);
				end else begin
					want = expected_runs.pop_front();
					compare_field("pixel_value", want.pixel, pix_if.pixel_value);
					compare_field("repeat_count", 32'(want.count), 32'(pix_if.repeat_count));
					compare_field("image_done", 32'(want.done), 32'(pix_if.image_done));
					compare_field("overflow_error", 32'(want.overflow),
						32'(pix_if.overflow_error));
				end
			end
			pix_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_if.valid && byte_if.ready) || (pix_if.valid && pix_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("** tga_rle_pixel_decoder: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic frame_start);
		coded_byte_t c;
		c.data        = b;
		c.frame_start = frame_start;
		byte_stream.push_back(c);
		bytes_queued++;
	endtask

	// Queues one image of roughly the given pixel count as raw and repeat packets.
	// A cut frame stops somewhere inside one of its packets.
	task automatic queue_frame(input int pixels, input int size, input bit cut);
		int left;
		int nmax;
		int n;
		int k;
		bit is_repeat;
		bit first;
		left  = pixels;
		first = 1'b1;
		while (left > 0) begin
			nmax = ($urandom_range(7) == 0) ? 128 : 6;
			if (nmax > left)
				nmax = left;
			is_repeat = 1'($urandom_range(1));
			if (is_repeat) begin
				n = $urandom_range(1, nmax);
				queue_byte(8'(int'(tga_pkg::REPEAT_BIAS) + n), first);
				k = size;
			end else begin
				// Long raw packets are expensive, so they stay short.
				n = $urandom_range(1, (nmax > 16) ? 16 : nmax);
				queue_byte(8'(n - 1), first);
				k = n * size;
			end
			first = 1'b0;
			left -= n;
			if (cut && (left <= 0 || $urandom_range(2) == 0)) begin
				repeat ($urandom_range(0, k - 1))
					queue_byte(8'($urandom), 1'b0);
				return;
			end
			repeat (k)
				queue_byte(8'($urandom), 1'b0);
		end
	endtask

	task automatic write_reg(input logic idx, input logic [tga_pkg::CFG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == tga_pkg::REG_BPP)
			cfg_bpp = value[tga_pkg::BPP_W-1:0];
		else
			cfg_total = value[tga_pkg::TOTAL_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every byte has been taken and every predicted run has arrived.
	task automatic settle();
		while (bytes_taken != bytes_queued || expected_runs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [tga_pkg::BPP_W-1:0]   phase_bpp[11];
		logic [tga_pkg::TOTAL_W-1:0] phase_total[11];
		int                          idle_send[4];
		int                          idle_recv[4];
		int                          start;
		int                          pick;
		int                          px;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = tga_pkg::REG_BPP;
		cfg_data            = '0;
		byte_if.valid       = 1'b0;
		byte_if.data_byte   = '0;
		byte_if.frame_start = 1'b0;
		pix_if.ready        = 1'b0;
		bytes_queued        = 0;
		bytes_taken         = 0;
		mismatches          = 0;
		quiet_cycles        = 0;
		send_idle_pct       = 0;
		recv_stall_pct      = 0;
		cfg_bpp             = tga_pkg::BPP_RESET;
		cfg_total           = tga_pkg::TOTAL_RESET;
		clear_decoder();
		phase_bpp   = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd5, 3'd6, 3'd7, 3'd1, 3'd3, 3'd2};
		phase_total = '{25'd5, 25'd3, 25'd7, 25'd1, 25'd4, 25'd6, 25'd3, 25'd2, 25'd0,
			25'd16777216, 25'd33554431};
		idle_send = '{0, 77, 0, 17};
		idle_recv = '{0, 0, 77, 17};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: four bytes per pixel and a one-pixel image, so the
		// first pixel completes it and the next byte is dropped.
		queue_byte(8'h00, 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h55, 1'b0);
		// A full 128-pixel repeat run against a one-pixel image overflows.
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'h12, 1'b0);
		queue_byte(8'h34, 1'b0);
		queue_byte(8'h56, 1'b0);
		queue_byte(8'h78, 1'b0);
		settle();

		// An image of no pixels overflows on its first pixel.
		write_reg(tga_pkg::REG_BPP, tga_pkg::CFG_W'(tga_pkg::BPP_MIN));
		write_reg(tga_pkg::REG_TOTAL, '0);
		queue_byte(8'h80, 1'b1);
		queue_byte(8'hAB, 1'b0);
		settle();

		write_reg(tga_pkg::REG_TOTAL, tga_pkg::CFG_W'(300));
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h80, 1'b0);
		settle();

		// Pixel sizes outside one to four are clamped.
		write_reg(tga_pkg::REG_BPP, '0);
		queue_byte(8'h80, 1'b1);
		queue_byte(8'h11, 1'b0);
		settle();
		write_reg(tga_pkg::REG_BPP, tga_pkg::CFG_W'(7));
		queue_byte(8'h81, 1'b1);
		queue_byte(8'hA5, 1'b0);
		queue_byte(8'h5A, 1'b0);
		queue_byte(8'hC3, 1'b0);
		queue_byte(8'h3C, 1'b0);
		settle();

		for (int p = 0; p < 11; p++) begin
			send_idle_pct  = idle_send[p % 4];
			recv_stall_pct = idle_recv[p % 4];
			write_reg(tga_pkg::REG_BPP, tga_pkg::CFG_W'(phase_bpp[p]));
			write_reg(tga_pkg::REG_TOTAL, tga_pkg::CFG_W'(phase_total[p]));
			start = bytes_queued;
			while (bytes_queued - start < 40) begin
				pick = $urandom_range(9);
				if (pick < 7) begin
					// Mostly whole images: exact, one short, or running past the total.
					if (phase_total[p] > 40)
						px = $urandom_range(1, 30);
					else
						px = int'(phase_total[p]) + $urandom_range(0, 2) - 1;
					if (px < 1)
						px = 1;
					queue_frame(px, pixel_bytes(phase_bpp[p]), 1'b0);
				end else if (pick == 7) begin
					queue_frame($urandom_range(1, 12), pixel_bytes(phase_bpp[p]), 1'b1);
				end else begin
					repeat ($urandom_range(1, 6))
						queue_byte(8'($urandom), ($urandom_range(9) == 0));
				end
			end
			settle();
		end

		if (mismatches == 0)
			$display("** tga_rle_pixel_decoder: PASSED **");
		else
			$display("** tga_rle_pixel_decoder: FAILED **");
		$finish;
	end

endmodule
